>>> design/ptt_pkg.sv
package ptt_pkg;

    // Field widths of the channels and of the stored timer state.
    localparam int OPCODE_W = 2;
    localparam int ID_W     = 32;
    localparam int PERIOD_W = 32;
    localparam int TIME_W   = 64;
    localparam int TICK_W   = 16;
    localparam int KIND_W   = 3;

    // Tick period after reset, in microseconds.
    localparam logic [TICK_W-1:0] TICK_PERIOD_RESET = 16'd500;

    // Command opcodes.
    localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REGISTER = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NOP      = 2'd3;

    // Event kinds reported on the result channel.
    localparam logic [KIND_W-1:0] EV_ASSIGNED  = 3'd0;
    localparam logic [KIND_W-1:0] EV_FIRED     = 3'd1;
    localparam logic [KIND_W-1:0] EV_FULL      = 3'd2;
    localparam logic [KIND_W-1:0] EV_DELETED   = 3'd3;
    localparam logic [KIND_W-1:0] EV_NOT_FOUND = 3'd4;
    localparam logic [KIND_W-1:0] EV_NONE_DUE  = 3'd5;

    // One row of the timer table.
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   last_fired;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic step;
        logic emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic walk_last;
        logic stall;
        logic out_free;
    } ctl_status_t;

endpackage

>>> design/ptt_cmd_if.sv
interface ptt_cmd_if;
    import ptt_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [PERIOD_W-1:0] period_us;
    logic [ID_W-1:0]     target_id;

    modport source (output valid, output opcode, output period_us, output target_id,
                    input ready);
    modport sink (input valid, input opcode, input period_us, input target_id,
                  output ready);
endinterface

>>> design/ptt_evt_if.sv
interface ptt_evt_if;
    import ptt_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [ID_W-1:0]   timer_id;
    logic              is_last;

    modport source (output valid, output event_kind, output timer_id, output is_last,
                    input ready);
    modport sink (input valid, input event_kind, input timer_id, input is_last,
                  output ready);
endinterface

>>> design/ptt_ctrl.sv
module ptt_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ptt_pkg::OPCODE_W-1:0]  in_opcode,
    output logic                          in_ready,
    input  ptt_pkg::ctl_status_t          status,
    output ptt_pkg::ctl_cmd_t             ctl
);
    import ptt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Commands follow directly from the state and the datapath status.
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        ctl.accept = (state_reg == ST_IDLE) && in_valid;
        ctl.step   = (state_reg == ST_WALK) && !status.stall;
        ctl.emit   = (state_reg == ST_EMIT) && status.out_free;
    end

    // Tick and delete walk the table unless it is empty; register goes straight to the final result.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_opcode)
                        OP_TICK, OP_DELETE:
                            state_next = status.count_zero ? ST_EMIT : ST_WALK;
                        OP_REGISTER:
                            state_next = ST_EMIT;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (!status.stall && status.walk_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> design/ptt_datapath.sv
module ptt_datapath #(
    parameter int MAX_TIMERS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptt_pkg::ctl_cmd_t             ctl,
    output ptt_pkg::ctl_status_t          status,
    input  logic [ptt_pkg::OPCODE_W-1:0]  in_opcode,
    input  logic [ptt_pkg::PERIOD_W-1:0]  in_period_us,
    input  logic [ptt_pkg::ID_W-1:0]      in_target_id,
    input  logic                          cfg_wr_en,
    input  logic [ptt_pkg::TICK_W-1:0]    cfg_wr_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [ptt_pkg::KIND_W-1:0]    out_event_kind,
    output logic [ptt_pkg::ID_W-1:0]      out_timer_id,
    output logic                          out_is_last
);
    import ptt_pkg::*;

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    // Timer table and its registered read port.
    entry_t mem [MAX_TIMERS];
    entry_t rd_data_reg;

    // Control state.
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [TICK_W-1:0] tick_period_reg, tick_period_next;
    logic              held_valid_reg, held_valid_next;
    logic              out_valid_reg, out_valid_next;

    // Per-transaction payload registers.
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [ID_W-1:0]     target_reg, target_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    keep_reg, keep_next;
    logic [KIND_W-1:0]   held_kind_reg, held_kind_next;
    logic [ID_W-1:0]     held_id_reg, held_id_next;
    logic [KIND_W-1:0]   out_kind_reg, out_kind_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic                out_last_reg, out_last_next;

    // Memory port controls.
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // Walk evaluation on the entry held in the registered read port.
    logic [TIME_W-1:0] elapsed;
    logic              due;
    logic              match;
    logic              is_tick;
    logic              full;
    logic              count_zero;
    logic              walk_last;
    logic              out_free;
    logic              fire_step;
    logic [ID_W-1:0]   new_id;

    always_comb
    begin
        elapsed    = time_reg - rd_data_reg.last_fired;
        due        = (elapsed >= TIME_W'(rd_data_reg.period));
        match      = (rd_data_reg.id == target_reg);
        is_tick    = (op_reg == OP_TICK);
        full       = (count_reg == CNT_W'(MAX_TIMERS));
        count_zero = (count_reg == '0);
        walk_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
        out_free   = !out_valid_reg || out_ready;
        fire_step  = ctl.step && is_tick && due;
        new_id     = next_id_reg + ID_W'(1);
    end

    always_comb
    begin
        status.count_zero = count_zero;
        status.walk_last  = walk_last;
        status.stall      = is_tick && due && held_valid_reg && !out_free;
        status.out_free   = out_free;
    end

    // Table write port: append on register, timestamp on fire, compaction on delete.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = rd_data_reg;
        if (ctl.accept && (in_opcode == OP_REGISTER) && !full)
        begin
            mem_we               = 1'b1;
            mem_waddr            = count_reg[IDX_W-1:0];
            mem_wdata.id         = new_id;
            mem_wdata.period     = in_period_us;
            mem_wdata.last_fired = '0;
        end
        else if (fire_step)
        begin
            mem_we               = 1'b1;
            mem_waddr            = idx_reg;
            mem_wdata.last_fired = time_reg;
        end
        else if (ctl.step && !is_tick && !match)
        begin
            mem_we    = 1'b1;
            mem_waddr = keep_reg[IDX_W-1:0];
        end
    end

    // Table read port: first entry on accept, then the following entry per step.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (ctl.accept && ((in_opcode == OP_TICK) || (in_opcode == OP_DELETE)) && !count_zero)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        else if (ctl.step && !walk_last)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg + IDX_W'(1);
        end
    end

    // Next-state logic for the timer state, the held result and the output register.
    always_comb
    begin
        count_next       = count_reg;
        time_next        = time_reg;
        next_id_next     = next_id_reg;
        tick_period_next = cfg_wr_en ? cfg_wr_data : tick_period_reg;
        held_valid_next  = held_valid_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        op_next          = op_reg;
        target_next      = target_reg;
        idx_next         = idx_reg;
        keep_next        = keep_reg;
        held_kind_next   = held_kind_reg;
        held_id_next     = held_id_reg;
        out_kind_next    = out_kind_reg;
        out_id_next      = out_id_reg;
        out_last_next    = out_last_reg;

        if (ctl.accept)
        begin
            op_next     = in_opcode;
            target_next = in_target_id;
            idx_next    = '0;
            keep_next   = '0;
            case (in_opcode)
                OP_TICK:
                begin
                    time_next       = time_reg + TIME_W'(tick_period_reg);
                    held_valid_next = 1'b0;
                end
                OP_REGISTER:
                begin
                    held_valid_next = 1'b1;
                    if (full)
                    begin
                        held_kind_next = EV_FULL;
                        held_id_next   = '0;
                    end
                    else
                    begin
                        held_kind_next = EV_ASSIGNED;
                        held_id_next   = new_id;
                        next_id_next   = new_id;
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                OP_DELETE:
                begin
                    held_valid_next = 1'b1;
                    held_kind_next  = EV_NOT_FOUND;
                    held_id_next    = '0;
                end
                default:
                begin
                    held_valid_next = held_valid_reg;
                end
            endcase
        end

        if (ctl.step)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (is_tick)
            begin
                if (due)
                begin
                    // The previous fired result is not the last one; pass it on.
                    if (held_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = held_kind_reg;
                        out_id_next    = held_id_reg;
                        out_last_next  = 1'b0;
                    end
                    held_valid_next = 1'b1;
                    held_kind_next  = EV_FIRED;
                    held_id_next    = rd_data_reg.id;
                end
            end
            else
            begin
                if (match)
                begin
                    held_kind_next = EV_DELETED;
                    held_id_next   = target_reg;
                end
                else
                begin
                    keep_next = keep_reg + CNT_W'(1);
                end
                if (walk_last)
                    count_next = match ? keep_reg : (keep_reg + CNT_W'(1));
            end
        end

        // Final result of the transaction.
        if (ctl.emit)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = held_valid_reg ? held_kind_reg : EV_NONE_DUE;
            out_id_next     = held_valid_reg ? held_id_reg : '0;
            out_last_next   = 1'b1;
            held_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            time_reg        <= '0;
            next_id_reg     <= '0;
            tick_period_reg <= TICK_PERIOD_RESET;
            held_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            time_reg        <= time_next;
            next_id_reg     <= next_id_next;
            tick_period_reg <= tick_period_next;
            held_valid_reg  <= held_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        target_reg    <= target_next;
        idx_reg       <= idx_next;
        keep_reg      <= keep_next;
        held_kind_reg <= held_kind_next;
        held_id_reg   <= held_id_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_last_reg  <= out_last_next;
    end

    // Timer table memory with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign out_valid      = out_valid_reg;
    assign out_event_kind = out_kind_reg;
    assign out_timer_id   = out_id_reg;
    assign out_is_last    = out_last_reg;

endmodule

>>> design/periodic_timer_table_core.sv
// Channel   Direction  Contents
// cmd       in         opcode, period_us, target_id
// evt       out        event_kind, timer_id, is_last
// cfg       in         cfg_wr_en, cfg_wr_data (tick period in microseconds)
//
// Register and unused opcodes are accepted from idle; register then emits its result.
// Tick and delete walk the table, one table entry per cycle unless the walk is held, through the
// timer table memory and its registered read port, then emit the final result.
// A stalled result channel holds the walk only when a second fired timer is ready to report.
// Reset is asynchronous and active low; it empties the table, clears time and ids,
// and sets the tick period to 500 microseconds.
module periodic_timer_table_core #(
    parameter int MAX_TIMERS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ptt_pkg::TICK_W-1:0]  cfg_wr_data,
    ptt_cmd_if.sink                     cmd,
    ptt_evt_if.source                   evt
);
    import ptt_pkg::*;

    ctl_cmd_t    ctl;
    ctl_status_t status;

    // Sequencer for the transactions.
    ptt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_opcode (cmd.opcode),
        .in_ready  (cmd.ready),
        .status    (status),
        .ctl       (ctl)
    );

    // Timer table, time base and result registers.
    ptt_datapath #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .status         (status),
        .in_opcode      (cmd.opcode),
        .in_period_us   (cmd.period_us),
        .in_target_id   (cmd.target_id),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .out_ready      (evt.ready),
        .out_valid      (evt.valid),
        .out_event_kind (evt.event_kind),
        .out_timer_id   (evt.timer_id),
        .out_is_last    (evt.is_last)
    );

endmodule

>>> design/ptt_checker.sv
module ptt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic [ptt_pkg::OPCODE_W-1:0] cmd_opcode,
    input logic                        evt_valid,
    input logic                        evt_ready,
    input logic [ptt_pkg::KIND_W-1:0]  evt_event_kind,
    input logic [ptt_pkg::ID_W-1:0]    evt_timer_id,
    input logic                        evt_is_last
);
    import ptt_pkg::*;

    // A result that waits on the sink keeps its contents.
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt_event_kind)
            && $stable(evt_timer_id) && $stable(evt_is_last))
        else $error("result changed while stalled");

    // A real command keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_opcode != OP_NOP) |=> !cmd_ready)
        else $error("command accepted while previous one still in work");

    // Only fired timers can be followed by further results of the same transaction.
    a_only_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_is_last |-> evt_event_kind == EV_FIRED)
        else $error("non-final result that is not a fired timer");

    // Results without a timer carry id zero.
    a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && ((evt_event_kind == EV_FULL) || (evt_event_kind == EV_NOT_FOUND)
            || (evt_event_kind == EV_NONE_DUE)) |-> evt_timer_id == '0 && evt_is_last)
        else $error("id-less result with nonzero id or not final");

endmodule

bind periodic_timer_table_core ptt_checker u_ptt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_opcode     (cmd.opcode),
    .evt_valid      (evt.valid),
    .evt_ready      (evt.ready),
    .evt_event_kind (evt.event_kind),
    .evt_timer_id   (evt.timer_id),
    .evt_is_last    (evt.is_last)
);

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ptt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 600000;
    // A tick or delete walks the whole table; this wait covers it.
    localparam int WALK_SETTLE = 40;

    // One expected result on the event channel.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } timer_event_t;

    // Tracks the timer table from accepted commands and checks every reported event.
    class timer_scoreboard;
        entry_t            table_q[$];
        logic [TIME_W-1:0] now_us;
        logic [ID_W-1:0]   last_id;
        logic [TICK_W-1:0] tick_us;
        timer_event_t      pending[$];
        int                errors;

        function new();
            now_us  = '0;
            last_id = '0;
            tick_us = TICK_PERIOD_RESET;
            errors  = 0;
        endfunction

        function void set_tick(input logic [TICK_W-1:0] value);
            tick_us = value;
        endfunction

        function void push_result(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
            timer_event_t ev;
            ev.kind = kind;
            ev.id   = id;
            ev.last = 1'b0;
            pending = {pending, ev};
        endfunction

        // Work out the events that one accepted command transaction causes.
        function void note_command(input logic [OPCODE_W-1:0] opcode,
                                   input logic [PERIOD_W-1:0] period,
                                   input logic [ID_W-1:0]     target);
            entry_t kept[$];
            entry_t row;
            int     fired;
            logic   found;
            fired = 0;
            found = 1'b0;
            case (opcode)
                OP_TICK:
                begin
                    now_us = now_us + TIME_W'(tick_us);
                    for (int i = 0; i < table_q.size(); i++)
                    begin
                        row = table_q[i];
                        if (now_us - row.last_fired >= TIME_W'(row.period))
                        begin
                            row.last_fired = now_us;
                            table_q[i] = row;
                            push_result(EV_FIRED, row.id);
                            fired++;
                        end
                    end
                    if (fired == 0)
                        push_result(EV_NONE_DUE, '0);
                end
                OP_REGISTER:
                begin
                    if (table_q.size() >= TABLE_DEPTH)
                        push_result(EV_FULL, '0);
                    else
                    begin
                        last_id        = last_id + ID_W'(1);
                        row.id         = last_id;
                        row.period     = period;
                        row.last_fired = '0;
                        table_q        = {table_q, row};
                        push_result(EV_ASSIGNED, last_id);
                    end
                end
                OP_DELETE:
                begin
                    foreach (table_q[i])
                    begin
                        if (table_q[i].id == target)
                            found = 1'b1;
                        else
                            kept = {kept, table_q[i]};
                    end
                    table_q = kept;
                    if (found)
                        push_result(EV_DELETED, target);
                    else
                        push_result(EV_NOT_FOUND, '0);
                end
                default:
                    return;
            endcase
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        // Compare one accepted event transaction with the oldest expectation.
        function void check_event(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                  input logic last);
            timer_event_t exp_ev;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected event, expected none, actual kind %0d id %0d last %0b",
                         $time, kind, id, last);
                return;
            end
            exp_ev = pending.pop_front();
            if (kind !== exp_ev.kind)
            begin
                errors++;
                $display("%0t: event_kind mismatch, expected %0d, actual %0d",
                         $time, exp_ev.kind, kind);
            end
            if (id !== exp_ev.id)
            begin
                errors++;
                $display("%0t: timer_id mismatch, expected %0d, actual %0d",
                         $time, exp_ev.id, id);
            end
            if (last !== exp_ev.last)
            begin
                errors++;
                $display("%0t: is_last mismatch, expected %0b, actual %0b",
                         $time, exp_ev.last, last);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [TICK_W-1:0]   cfg_wr_data;
    logic                idle_on;
    int unsigned         cycle_count;
    int unsigned         hold_cycles;
    int unsigned         quiet_cycles;
    timer_scoreboard     board = new();

    ptt_cmd_if cmd_bus();
    ptt_evt_if evt_bus();

    periodic_timer_table_core #(
        .MAX_TIMERS(TABLE_DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .cmd        (cmd_bus),
        .evt        (evt_bus)
    );

    // Clock generation.
    always #2 clk = ~clk;

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Back-pressure on the event channel while idling is on: random stall bursts with quiet stretches between.
    always @(negedge clk)
    begin
        if (!idle_on)
            evt_bus.ready <= 1'b1;
        else if (hold_cycles != 0)
        begin
            hold_cycles = hold_cycles - 1;
            evt_bus.ready <= 1'b0;
        end
        else if (quiet_cycles != 0)
        begin
            quiet_cycles = quiet_cycles - 1;
            evt_bus.ready <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            hold_cycles = $urandom_range(0, 12);
            evt_bus.ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 9) == 0)
                quiet_cycles = $urandom_range(20, 60);
            evt_bus.ready <= 1'b1;
        end
    end

    // Event monitor.
    always @(posedge clk)
    begin
        if (rst_n && evt_bus.valid === 1'b1 && evt_bus.ready === 1'b1)
            board.check_event(evt_bus.event_kind, evt_bus.timer_id, evt_bus.is_last);
    end

    // Present one command transaction and wait until it is taken.
    task automatic send_command(input logic [OPCODE_W-1:0] opcode,
                                input logic [PERIOD_W-1:0] period,
                                input logic [ID_W-1:0]     target);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.opcode    <= opcode;
        cmd_bus.period_us <= period;
        cmd_bus.target_id <= target;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);
        board.note_command(opcode, period, target);
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected event has come and the walk is done.
    task automatic drain_events();
        cmd_bus.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (WALK_SETTLE) @(negedge clk);
    endtask

    task automatic write_tick_period(input logic [TICK_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        board.set_tick(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random traffic: mostly ticks, registers and deletes of live ids, some noise.
    task automatic run_random_phase(input int count);
        int                  done;
        int unsigned         pick;
        logic [PERIOD_W-1:0] period;
        logic [ID_W-1:0]     target;
        done = 0;
        while (done < count)
        begin
            pick   = $urandom_range(0, 99);
            period = $urandom();
            target = $urandom();
            if (pick < 5)
                send_command(OP_NOP, period, target);
            else
            begin
                if (pick < 45)
                    send_command(OP_TICK, period, target);
                else if (pick < 72)
                begin
                    if ($urandom_range(0, 4) != 0)
                        period = $urandom_range(0, 4 * int'(board.tick_us) + 1);
                    send_command(OP_REGISTER, period, target);
                end
                else
                begin
                    if (board.table_q.size() != 0 && $urandom_range(0, 3) != 0)
                        target = board.table_q[$urandom_range(0, board.table_q.size() - 1)].id;
                    send_command(OP_DELETE, period, target);
                end
                done++;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        idle_on           = 1'b1;
        cycle_count       = 0;
        hold_cycles       = 0;
        quiet_cycles      = 0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.opcode    = OP_TICK;
        cmd_bus.period_us = '0;
        cmd_bus.target_id = '0;
        evt_bus.ready     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (WALK_SETTLE) @(negedge clk);

        // Directed: empty table, extreme fields, the unused opcode, table full, many due.
        send_command(OP_TICK, '1, '1);
        send_command(OP_DELETE, '0, '0);
        send_command(OP_DELETE, '1, '1);
        send_command(OP_REGISTER, '0, '0);
        send_command(OP_REGISTER, '1, '0);
        send_command(OP_REGISTER, 32'd1000, '1);
        send_command(OP_TICK, '0, '0);
        send_command(OP_TICK, '0, '0);
        send_command(OP_NOP, $urandom(), $urandom());
        send_command(OP_DELETE, '0, 32'd2);
        for (int i = 0; i < TABLE_DEPTH - 1; i++)
            send_command(OP_REGISTER, '0, '0);
        send_command(OP_TICK, '0, '0);
        drain_events();

        // Random phases over several tick periods, the extremes among them.
        write_tick_period(16'hFFFF);
        run_random_phase(36);
        drain_events();
        write_tick_period(16'd1);
        run_random_phase(36);
        drain_events();
        write_tick_period(16'd0);
        run_random_phase(36);
        drain_events();
        write_tick_period(TICK_W'($urandom_range(2, 65534)));
        run_random_phase(36);
        drain_events();

        // Last phase runs without any idling.
        idle_on = 1'b0;
        write_tick_period(16'd500);
        run_random_phase(36);
        drain_events();

        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
